FILE: design/tis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trie insertion step package
// Shared widths, command and kind codes, and the queued item type.
// ----------------------------------------------------------------------------
package tis_pkg;

   localparam int NODES_DEF    = 1024;
   localparam int ALPHABET_DEF = 32;

   localparam int NODE_W     = 10;
   localparam int SYM_W      = 5;
   localparam int HITS_W     = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   localparam logic [HITS_W-1:0] HITS_MAX = '1;

   localparam logic CMD_CLEAR = 1'b1;

   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROP  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] node;
      logic [SYM_W-1:0]  symbol;
      logic              terminal;
   } item_type;

endpackage
`default_nettype wire

FILE: design/tis_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trie insertion front end
// Unpacks request items and sorts them into add, clear and drop kinds.
// ----------------------------------------------------------------------------
module tis_front
   import tis_pkg::*;
#(
   parameter int NODES    = NODES_DEF,
   parameter int ALPHABET = ALPHABET_DEF
) (
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // node, symbol, zero pad
   input  wire logic                  req_tuser,  // cmd
   input  wire logic                  req_tlast,  // terminal
   input  wire logic                  q_full,
   output logic                       push,
   output item_type                   item
);

   always_comb begin
      item.node     = req_tdata[NODE_W-1:0];
      item.symbol   = req_tdata[NODE_W +: SYM_W];
      item.terminal = req_tlast;
      if (req_tuser == CMD_CLEAR) begin
         item.kind = KIND_CLEAR;
      end else if ((32'(item.node) >= NODES) || (32'(item.symbol) >= ALPHABET)) begin
         item.kind = KIND_DROP;
      end else begin
         item.kind = KIND_ADD;
      end
   end

   assign req_tready = ~q_full;
   assign push       = req_tvalid & ~q_full;

endmodule
`default_nettype wire

FILE: design/tis_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trie insertion item queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tis_queue
   import tis_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          valid,
   output item_type      head
);

   item_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ff, wr_in;
   logic [QPTR_W-1:0]     rd_ff, rd_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;

   assign full  = reset | (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/tis_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trie insertion back end
// Holds the node pool and carries out add, clear and drop items one at a time.
// ----------------------------------------------------------------------------
module tis_back
   import tis_pkg::*;
#(
   parameter int NODES    = NODES_DEF,
   parameter int ALPHABET = ALPHABET_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire item_type              q_head,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   localparam int IDX_W   = $clog2(NODES);
   localparam int SIW     = $clog2(ALPHABET);
   localparam int ENTRIES = NODES * ALPHABET;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int USED_W  = $clog2(NODES + 1);

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_LOOK = 3'd2;
   localparam logic [2:0] S_CNT  = 3'd3;
   localparam logic [2:0] S_LINK = 3'd4;

   function automatic logic [IDX_W-1:0] to_idx(input logic [NODE_W-1:0] n);
      logic [NODE_W+IDX_W-1:0] w;
      w = (NODE_W + IDX_W)'(n);
      return w[IDX_W-1:0];
   endfunction

   function automatic logic [NODE_W-1:0] to_child(input logic [IDX_W-1:0] n);
      logic [NODE_W+IDX_W-1:0] w;
      w = (NODE_W + IDX_W)'(n);
      return w[NODE_W-1:0];
   endfunction

   function automatic logic [SIW-1:0] to_sym(input logic [SYM_W-1:0] s);
      logic [SYM_W+SIW-1:0] w;
      w = (SYM_W + SIW)'(s);
      return w[SIW-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] link_addr(input logic [NODE_W-1:0] n,
                                                   input logic [SYM_W-1:0] s);
      logic [31:0] a;
      a = 32'(n) * 32'(ALPHABET) + 32'(s);
      return a[ADDR_W-1:0];
   endfunction

   logic [ALPHABET-1:0] pres_mem [NODES];
   logic [IDX_W-1:0]    link_mem [ENTRIES];
   logic [HITS_W-1:0]   hits_mem [NODES];

   logic [ALPHABET-1:0] row_ff;
   logic [IDX_W-1:0]    link_ff;
   logic [HITS_W-1:0]   hits_ff;

   logic [2:0]            state_ff, state_in;
   logic [USED_W-1:0]     used_ff, used_in;
   item_type              cur_ff, cur_in;
   logic [IDX_W-1:0]      to_ff, to_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                  pres_re, pres_we, link_re, link_we, hits_re, hits_we;
   logic [IDX_W-1:0]      pres_raddr, pres_waddr, hits_raddr, hits_waddr;
   logic [ALPHABET-1:0]   pres_wdata;
   logic [ADDR_W-1:0]     link_raddr, link_waddr;
   logic [IDX_W-1:0]      link_wdata;
   logic [HITS_W-1:0]     hits_wdata;

   logic                  out_free, present, node_live;
   logic [ALPHABET-1:0]   sym_bit;
   logic [IDX_W-1:0]      to_sel, fresh;
   logic [HITS_W-1:0]     hits_next;
   logic                  res_fire, res_created, res_full;
   logic [NODE_W-1:0]     res_child;
   logic [HITS_W-1:0]     res_hits;

   always_comb begin
      out_free   = ~rsp_valid_ff | rsp_tready;
      sym_bit    = {{(ALPHABET-1){1'b0}}, 1'b1} << to_sym(cur_ff.symbol);
      present    = |(row_ff & sym_bit);
      node_live  = 32'(cur_ff.node) < 32'(used_ff);
      to_sel     = (32'(link_ff) >= NODES) ? '0 : link_ff;
      fresh      = used_ff[IDX_W-1:0];
      hits_next  = (cur_ff.terminal && (hits_ff != HITS_MAX)) ? hits_ff + 1'b1 : hits_ff;
      pres_raddr = to_idx(q_head.node);
      link_raddr = link_addr(q_head.node, q_head.symbol);
   end

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      cur_in      = cur_ff;
      to_in       = to_ff;
      pop         = 1'b0;
      pres_re     = 1'b0;
      pres_we     = 1'b0;
      pres_waddr  = '0;
      pres_wdata  = '0;
      link_re     = 1'b0;
      link_we     = 1'b0;
      link_waddr  = link_addr(cur_ff.node, cur_ff.symbol);
      link_wdata  = fresh;
      hits_re     = 1'b0;
      hits_raddr  = to_sel;
      hits_we     = 1'b0;
      hits_waddr  = '0;
      hits_wdata  = '0;
      res_fire    = 1'b0;
      res_child   = cur_ff.node;
      res_created = 1'b0;
      res_full    = 1'b0;
      res_hits    = '0;
      case (state_ff)
         S_INIT: begin
            pres_we  = 1'b1;
            hits_we  = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               cur_in   = q_head;
               pres_re  = 1'b1;
               link_re  = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            case (cur_ff.kind)
               KIND_CLEAR: begin
                  if (out_free) begin
                     pres_we   = 1'b1;
                     hits_we   = 1'b1;
                     used_in   = USED_W'(1);
                     res_fire  = 1'b1;
                     res_child = '0;
                     state_in  = S_IDLE;
                  end
               end
               KIND_ADD: begin
                  if (!node_live) begin
                     if (out_free) begin
                        res_fire = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else if (present) begin
                     to_in    = to_sel;
                     hits_re  = 1'b1;
                     state_in = S_CNT;
                  end else if (32'(used_ff) >= NODES) begin
                     if (out_free) begin
                        res_fire = 1'b1;
                        res_full = 1'b1;
                        state_in = S_IDLE;
                     end
                  end else if (out_free) begin
                     pres_we     = 1'b1;
                     pres_waddr  = fresh;
                     link_we     = 1'b1;
                     hits_we     = 1'b1;
                     hits_waddr  = fresh;
                     hits_wdata  = HITS_W'(cur_ff.terminal);
                     used_in     = used_ff + 1'b1;
                     res_fire    = 1'b1;
                     res_child   = to_child(fresh);
                     res_created = 1'b1;
                     res_hits    = HITS_W'(cur_ff.terminal);
                     state_in    = S_LINK;
                  end
               end
               default: begin
                  if (out_free) begin
                     res_fire = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_CNT: begin
            if (out_free) begin
               hits_we    = 1'b1;
               hits_waddr = to_ff;
               hits_wdata = hits_next;
               res_fire   = 1'b1;
               res_child  = to_child(to_ff);
               res_hits   = hits_next;
               state_in   = S_IDLE;
            end
         end
         S_LINK: begin
            pres_we    = 1'b1;
            pres_waddr = to_idx(cur_ff.node);
            pres_wdata = row_ff | sym_bit;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = res_fire | (rsp_valid_ff & ~rsp_tready);
      rsp_data_in  = res_fire ? RSP_DATA_W'({res_hits, res_child}) : rsp_data_ff;
      rsp_user_in  = res_fire ? {res_full, res_created} : rsp_user_ff;
   end

   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[pres_waddr] <= pres_wdata;
      end
      if (pres_re) begin
         row_ff <= pres_mem[pres_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_ff <= link_mem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (hits_we) begin
         hits_mem[hits_waddr] <= hits_wdata;
      end
      if (hits_re) begin
         hits_ff <= hits_mem[hits_raddr];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      to_ff       <= to_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         used_ff      <= USED_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

FILE: design/trie_insert_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trie insertion step
// Adds one symbol under a node of a trie kept in a fixed pool of nodes.
// ----------------------------------------------------------------------------
// Each request item yields one response item. In the back end an item first
// reads the node's child row and link entry in S_IDLE, then decides and writes
// in S_LOOK; following an existing child adds S_CNT, since the counter read
// depends on the link just read, and allocating a node adds S_LINK, since the
// parent's child row is written back in a state of its own. A two-entry queue
// lets the request side run ahead, and the response register lets the next
// item start while a response waits. After reset the root is set up in S_INIT
// before the first item is processed.
module trie_insert_step
   import tis_pkg::*;
#(
   parameter int NODES    = NODES_DEF,
   parameter int ALPHABET = ALPHABET_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // node, symbol, zero pad
   input  wire logic                  req_tuser,  // cmd
   input  wire logic                  req_tlast,  // terminal
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // child, hits, zero pad
   output logic [RSP_USER_W-1:0]      rsp_tuser   // created, pool_full
);

   logic     q_full, q_push, q_pop, q_valid;
   item_type q_in, q_head;

   tis_front #(
      .NODES    (NODES),
      .ALPHABET (ALPHABET)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (q_push),
      .item       (q_in)
   );

   tis_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   tis_back #(
      .NODES    (NODES),
      .ALPHABET (ALPHABET)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: tb/sv/trie_insert_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trie insertion step testbench
// Drives add and clear items through the request stream, predicts every
// response from a private copy of the trie and checks each response field.
// A directed table covers the edges, then filling the pool and random
// string walks follow, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module trie_insert_step_tb;
   import tis_pkg::*;

   localparam logic CMD_ADD     = ~CMD_CLEAR;
   localparam int   CYCLE_LIMIT = 4_000_000;
   localparam int   DRAIN_WAIT  = 12;
   localparam int   ITEM_COUNT  = 1800;

   typedef struct packed {
      logic [NODE_W-1:0] child;
      logic              created;
      logic              pool_full;
      logic [HITS_W-1:0] hits;
   } step_result_type;

   typedef struct packed {
      logic              cmd;
      logic [NODE_W-1:0] node;
      logic [SYM_W-1:0]  sym;
      logic              term;
      logic              fixed;
      step_result_type   want;
   } dir_row_type;

   localparam dir_row_type DIRECTED_ROWS [22] = '{
      '{CMD_ADD,   10'd0,    5'd0,  1'b0, 1'b1, '{10'd1,    1'b1, 1'b0, 16'd0}},
      '{CMD_ADD,   10'd0,    5'd31, 1'b1, 1'b1, '{10'd2,    1'b1, 1'b0, 16'd1}},
      '{CMD_ADD,   10'd0,    5'd0,  1'b1, 1'b1, '{10'd1,    1'b0, 1'b0, 16'd1}},
      '{CMD_ADD,   10'd1,    5'd31, 1'b1, 1'b0, '0},
      '{CMD_ADD,   10'd1023, 5'd5,  1'b0, 1'b1, '{10'd1023, 1'b0, 1'b0, 16'd0}},
      '{CMD_ADD,   10'd3,    5'd0,  1'b0, 1'b0, '0},
      '{CMD_ADD,   10'd2,    5'd31, 1'b1, 1'b0, '0},
      '{CMD_ADD,   10'd5,    5'd31, 1'b1, 1'b0, '0},
      '{CMD_ADD,   10'd2,    5'd31, 1'b1, 1'b0, '0},
      '{CMD_ADD,   10'd4,    5'd16, 1'b0, 1'b0, '0},
      '{CMD_ADD,   10'd512,  5'd10, 1'b1, 1'b1, '{10'd512,  1'b0, 1'b0, 16'd0}},
      '{CMD_ADD,   10'd8,    5'd0,  1'b1, 1'b1, '{10'd8,    1'b0, 1'b0, 16'd0}},
      '{CMD_ADD,   10'd7,    5'd21, 1'b1, 1'b0, '0},
      '{CMD_CLEAR, 10'd1023, 5'd31, 1'b1, 1'b1, '{10'd0,    1'b0, 1'b0, 16'd0}},
      '{CMD_ADD,   10'd0,    5'd0,  1'b1, 1'b1, '{10'd1,    1'b1, 1'b0, 16'd1}},
      '{CMD_ADD,   10'd1,    5'd31, 1'b1, 1'b1, '{10'd2,    1'b1, 1'b0, 16'd1}},
      '{CMD_ADD,   10'd2,    5'd0,  1'b0, 1'b0, '0},
      '{CMD_ADD,   10'd4,    5'd0,  1'b1, 1'b1, '{10'd4,    1'b0, 1'b0, 16'd0}},
      '{CMD_CLEAR, 10'd0,    5'd0,  1'b0, 1'b1, '{10'd0,    1'b0, 1'b0, 16'd0}},
      '{CMD_CLEAR, 10'd0,    5'd0,  1'b0, 1'b1, '{10'd0,    1'b0, 1'b0, 16'd0}},
      '{CMD_ADD,   10'd0,    5'd31, 1'b0, 1'b1, '{10'd1,    1'b1, 1'b0, 16'd0}},
      '{CMD_ADD,   10'd0,    5'd31, 1'b1, 1'b1, '{10'd1,    1'b0, 1'b0, 16'd1}}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // node, symbol, zero pad
   logic                  req_tuser = 1'b0;  // cmd
   logic                  req_tlast = 1'b0;  // terminal
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // child, hits, zero pad
   logic [RSP_USER_W-1:0] rsp_tuser;  // created, pool_full

   logic [ALPHABET_DEF-1:0] links_present [NODES_DEF];
   logic [NODE_W-1:0]       link_to [NODES_DEF*ALPHABET_DEF];
   logic [HITS_W-1:0]       node_hits [NODES_DEF];
   int unsigned             nodes_used;
   int unsigned             sent_items = 0;

   step_result_type awaited_steps [$];
   int              errors = 0;
   int              cycles = 0;
   int              burst_left = 0;
   bit              calm = 1'b0;
   int              hold_left = 0;

   trie_insert_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic step_result_type trie_step(input logic cmd,
                                                 input logic [NODE_W-1:0] node,
                                                 input logic [SYM_W-1:0] sym,
                                                 input logic term);
      step_result_type r;
      int unsigned     slot;
      int unsigned     to;
      int unsigned     fresh;
      r = '0;
      if (cmd == CMD_CLEAR) begin
         links_present[0] = '0;
         node_hits[0] = '0;
         nodes_used = 1;
         return r;
      end
      r.child = node;
      if (node >= nodes_used) begin
         return r;
      end
      slot = node * ALPHABET_DEF + sym;
      if (links_present[node][sym]) begin
         to = link_to[slot];
         if (term && node_hits[to] != HITS_MAX) begin
            node_hits[to] = node_hits[to] + 1'b1;
         end
         r.child = NODE_W'(to);
         r.hits = node_hits[to];
         return r;
      end
      if (nodes_used >= NODES_DEF) begin
         r.pool_full = 1'b1;
         return r;
      end
      fresh = nodes_used;
      nodes_used++;
      links_present[fresh] = '0;
      node_hits[fresh] = {{(HITS_W-1){1'b0}}, term};
      links_present[node][sym] = 1'b1;
      link_to[slot] = NODE_W'(fresh);
      r.child = NODE_W'(fresh);
      r.created = 1'b1;
      r.hits = {{(HITS_W-1){1'b0}}, term};
      return r;
   endfunction

   task automatic issue(input logic cmd, input logic [NODE_W-1:0] node,
                        input logic [SYM_W-1:0] sym, input logic term,
                        input logic fixed, input step_result_type want,
                        output step_result_type pred);
      int gap;
      sent_items++;
      pred = trie_step(cmd, node, sym, term);
      awaited_steps.push_back(fixed ? want : pred);
      if (burst_left == 0) begin
         if ($urandom_range(0, 19) == 0) begin
            calm = !calm;
         end
         burst_left = $urandom_range(1, 24);
         gap = calm ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= term;
      req_tdata  <= {{(REQ_DATA_W-NODE_W-SYM_W){1'b0}}, sym, node};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic walk_string(input int len, input int sym_span, input bit from_root);
      logic [NODE_W-1:0] at;
      step_result_type   got;
      at = from_root ? '0 : NODE_W'($urandom_range(0, nodes_used - 1));
      for (int k = 0; k < len; k++) begin
         issue(CMD_ADD, at, SYM_W'($urandom_range(0, sym_span)),
               (k == len - 1) ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0, '0, got);
         at = got.child;
      end
   endtask

   task automatic noise_item();
      logic [NODE_W-1:0] at;
      step_result_type   got;
      at = $urandom_range(0, 1) ? NODE_W'($urandom_range(0, NODES_DEF - 1))
                                : NODE_W'($urandom_range(0, nodes_used - 1));
      issue(CMD_ADD, at, SYM_W'($urandom), 1'($urandom), 1'b0, '0, got);
   endtask

   always @(posedge clock) begin
      step_result_type exp;
      step_result_type act;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act.child     = rsp_tdata[NODE_W-1:0];
         act.hits      = rsp_tdata[NODE_W +: HITS_W];
         act.created   = rsp_tuser[0];
         act.pool_full = rsp_tuser[1];
         if (awaited_steps.size() == 0) begin
            $error("unexpected response item: child %0d hits %0d", act.child, act.hits);
            errors++;
         end else begin
            exp = awaited_steps.pop_front();
            if (act.child !== exp.child) begin
               $error("child: expected %0d, got %0d", exp.child, act.child);
               errors++;
            end
            if (act.created !== exp.created) begin
               $error("created: expected %0d, got %0d", exp.created, act.created);
               errors++;
            end
            if (act.pool_full !== exp.pool_full) begin
               $error("pool_full: expected %0d, got %0d", exp.pool_full, act.pool_full);
               errors++;
            end
            if (act.hits !== exp.hits) begin
               $error("hits: expected %0d, got %0d", exp.hits, act.hits);
               errors++;
            end
         end
      end
      if (hold_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               rsp_tready <= 1'b0;
               hold_left = $urandom_range(1, 6);
            end
            2: begin
               rsp_tready <= 1'b1;
               hold_left = $urandom_range(40, 160);
            end
            default: begin
               rsp_tready <= 1'b1;
               hold_left = $urandom_range(1, 8);
            end
         endcase
      end else begin
         hold_left--;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      step_result_type got;
      nodes_used = 1;
      links_present[0] = '0;
      node_hits[0] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         issue(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].node, DIRECTED_ROWS[i].sym,
               DIRECTED_ROWS[i].term, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want, got);
      end

      // Grow the trie until the pool is exhausted, then keep walking into it.
      while (nodes_used < NODES_DEF) begin
         walk_string($urandom_range(1, 12), $urandom_range(0, 3) == 0 ? 3 : 31,
                     $urandom_range(0, 3) != 0);
      end
      for (int k = 0; k < 15; k++) begin
         walk_string($urandom_range(2, 8), 31, $urandom_range(0, 1));
         noise_item();
      end
      issue(CMD_CLEAR, NODE_W'($urandom), SYM_W'($urandom), 1'($urandom), 1'b0, '0, got);

      while (sent_items < ITEM_COUNT) begin
         case ($urandom_range(0, 19))
            0: issue(CMD_CLEAR, NODE_W'($urandom), SYM_W'($urandom), 1'($urandom),
                     1'b0, '0, got);
            1, 2, 3, 4: noise_item();
            default: walk_string($urandom_range(1, 12),
                                 $urandom_range(0, 1) ? 3 : 31,
                                 $urandom_range(0, 4) != 0);
         endcase
      end

      req_tvalid <= 1'b0;
      while (awaited_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
